/* src/rmsh_pkg.sv */
// Package with the types, codes and default constants of the segment histogram unit.
`default_nettype none

package rmsh_pkg;

	localparam int LINE_MAX_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COUNT_BITS_DEF  = 32;

	localparam int KIND_W  = 2;
	localparam int BIN_W   = 6;
	localparam int RATIO_W = 16;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd45875;

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_READ   = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HREAD,
		ST_START,
		ST_MUL,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* src/rmsh_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module rmsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/running_mean_segment_histogram_unit.sv */
// Top level of the running-mean line segmenter with its segment-length histogram.
//
//  Channel  Handshake           Payload
//  in       in_valid/in_stall   kind, sample, end_of_line, bin_index
//  out      out_valid/out_stall bin_count, bin_echo
//  cfg      cfg_write           cfg_data (threshold ratio)
//
// A sample or clear transaction is taken in idle; a histogram read then passes through ST_HREAD.
// A sample with end_of_line runs a search pass up to the first break and a full pass over
// the n stored samples, each sample in a multiply and then a compare state (ST_MUL, ST_CMP).
// After reset a clearing pass writes every histogram bin with in_stall high.
// In idle, a read transaction also waits while a previous result is still held by out_stall.
`default_nettype none

module running_mean_segment_histogram_unit #(
	parameter int LINE_MAX    = rmsh_pkg::LINE_MAX_DEF,
	parameter int SAMPLE_BITS = rmsh_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = rmsh_pkg::COUNT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [rmsh_pkg::RATIO_W-1:0] cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [rmsh_pkg::KIND_W-1:0]  kind,
	input  wire logic [SAMPLE_BITS-1:0]       sample,
	input  wire logic                         end_of_line,
	input  wire logic [rmsh_pkg::BIN_W-1:0]   bin_index,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [COUNT_BITS-1:0]        bin_count,
	output logic      [rmsh_pkg::BIN_W-1:0]   bin_echo
);

	import rmsh_pkg::*;

	localparam int AW        = $clog2(LINE_MAX);
	localparam int LEN_BITS  = $clog2(LINE_MAX + 1);
	localparam int SUM_BITS  = SAMPLE_BITS + LEN_BITS;
	localparam int PROD_BITS = SAMPLE_BITS + LEN_BITS + 1;
	localparam int DEV_BITS  = PROD_BITS + 1;
	localparam int RHS_BITS  = RATIO_W + SUM_BITS;
	localparam int CMP_BITS  = DEV_BITS + RATIO_W;

	state_t state_q, state_d;

	logic [RATIO_W-1:0]  ratio_q;
	logic [LEN_BITS-1:0] fill_q;
	logic [LEN_BITS-1:0] n_q;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       j_q;
	logic [AW-1:0]       clr_q;
	logic                pass2_q;
	logic                bump_q;
	logic [AW-1:0]       bump_addr_q;

	logic signed [SUM_BITS-1:0]  sum_q;
	logic        [LEN_BITS-1:0]  len_q;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic signed [PROD_BITS-1:0] prod_s1;
	logic        [RHS_BITS-1:0]  rhs_s1;

	logic                        bin_ok_q;
	logic [BIN_W-1:0]            bin_q;
	logic                        out_valid_q;
	logic [COUNT_BITS-1:0]       bin_count_q;

	logic                  in_take;
	logic                  bin_ok;
	logic [AW-1:0]         bin_addr;
	logic                  fill_room;
	logic                  last;
	logic [AW-1:0]         next_addr;
	logic [SUM_BITS-1:0]   sum_mag;
	logic signed [DEV_BITS-1:0] dev;
	logic [DEV_BITS-1:0]   dev_mag;
	logic                  brk;
	logic                  is_break;

	logic                  line_we;
	logic [AW-1:0]         line_waddr;
	logic [AW-1:0]         line_raddr;
	logic [SAMPLE_BITS-1:0] line_rdata;
	logic                  hist_we;
	logic [AW-1:0]         hist_waddr;
	logic [COUNT_BITS-1:0] hist_wdata;
	logic [AW-1:0]         hist_raddr;
	logic [COUNT_BITS-1:0] hist_rdata;
	logic [COUNT_BITS-1:0] bump_val;

	rmsh_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(LINE_MAX)
	) u_line_ram (
		.clk  (clk),
		.we   (line_we),
		.waddr(line_waddr),
		.wdata(sample),
		.raddr(line_raddr),
		.rdata(line_rdata)
	);

	rmsh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(LINE_MAX)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	assign in_take   = in_valid && !in_stall;
	assign bin_ok    = int'(bin_index) < LINE_MAX;
	assign bin_addr  = AW'(bin_index);
	assign fill_room = fill_q < LEN_BITS'(LINE_MAX);
	assign last      = (LEN_BITS'(j_q) + LEN_BITS'(1)) == n_q;
	assign next_addr = ((LEN_BITS'(addr_q) + LEN_BITS'(1)) == n_q) ? '0 : addr_q + AW'(1);

	assign sum_mag  = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
	assign dev      = DEV_BITS'(sum_q) - DEV_BITS'(prod_s1);
	assign dev_mag  = dev[DEV_BITS-1] ? DEV_BITS'(-dev) : DEV_BITS'(dev);
	assign brk      = {dev_mag, {RATIO_W{1'b0}}} > CMP_BITS'(rhs_s1);
	assign is_break = (len_q != '0) && brk;
	assign bump_val = (&hist_rdata) ? hist_rdata : hist_rdata + COUNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		line_we    = 1'b0;
		line_waddr = fill_q[AW-1:0];
		line_raddr = addr_q;
		hist_raddr = bin_addr;
		hist_we    = 1'b0;
		hist_waddr = bump_addr_q;
		hist_wdata = bump_val;
		unique case (state_q)
			ST_CLEAR: begin
				hist_we    = 1'b1;
				hist_waddr = clr_q;
				hist_wdata = '0;
				if (clr_q == AW'(LINE_MAX - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = (kind == KIND_READ) && out_valid_q && out_stall;
				if (in_take) begin
					unique case (kind_t'(kind))
						KIND_SAMPLE: begin
							line_we = fill_room;
							if (end_of_line) begin
								state_d = ST_START;
							end
						end
						KIND_READ: begin
							state_d = ST_HREAD;
						end
						KIND_CLEAR: begin
							hist_we    = bin_ok;
							hist_waddr = bin_addr;
							hist_wdata = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_HREAD: begin
				state_d = ST_IDLE;
			end
			ST_START: begin
				line_raddr = '0;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				hist_we = bump_q;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				hist_raddr = AW'(len_q);
				state_d    = ST_MUL;
				if (!pass2_q) begin
					if (is_break) begin
						line_raddr = addr_q;
					end else if (last) begin
						line_raddr = '0;
					end else begin
						line_raddr = next_addr;
					end
				end else begin
					line_raddr = next_addr;
					if (last) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				hist_we = bump_q;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_write) begin
			ratio_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			fill_q      <= '0;
			n_q         <= '0;
			addr_q      <= '0;
			j_q         <= '0;
			pass2_q     <= 1'b0;
			sum_q       <= '0;
			len_q       <= '0;
			bump_q      <= 1'b0;
			bump_addr_q <= '0;
		end else begin
			bump_q <= (state_q == ST_CMP) && pass2_q && is_break;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_IDLE && in_take && kind == KIND_SAMPLE) begin
				if (end_of_line) begin
					n_q     <= fill_room ? fill_q + LEN_BITS'(1) : fill_q;
					fill_q  <= '0;
					pass2_q <= 1'b0;
					sum_q   <= '0;
					len_q   <= '0;
					addr_q  <= '0;
					j_q     <= '0;
				end else if (fill_room) begin
					fill_q <= fill_q + LEN_BITS'(1);
				end
			end
			if (state_q == ST_CMP) begin
				bump_addr_q <= AW'(len_q);
				if (!pass2_q) begin
					if (is_break || last) begin
						pass2_q <= 1'b1;
						addr_q  <= is_break ? addr_q : '0;
						j_q     <= '0;
						sum_q   <= '0;
						len_q   <= '0;
					end else begin
						sum_q  <= sum_q + SUM_BITS'(x_s1);
						len_q  <= len_q + LEN_BITS'(1);
						addr_q <= next_addr;
						j_q    <= j_q + AW'(1);
					end
				end else begin
					addr_q <= next_addr;
					j_q    <= j_q + AW'(1);
					if (len_q == '0) begin
						sum_q <= SUM_BITS'(x_s1);
						len_q <= LEN_BITS'(1);
					end else if (brk) begin
						sum_q <= '0;
						len_q <= '0;
					end else begin
						sum_q <= sum_q + SUM_BITS'(x_s1);
						len_q <= len_q + LEN_BITS'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			x_s1    <= $signed(line_rdata);
			prod_s1 <= $signed(line_rdata) * $signed({1'b0, len_q});
			rhs_s1  <= ratio_q * sum_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HREAD) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_take) begin
			bin_ok_q <= bin_ok;
			bin_q    <= bin_index;
		end
		if (state_q == ST_HREAD) begin
			bin_count_q <= bin_ok_q ? hist_rdata : '0;
			bin_echo    <= bin_q;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_count = bin_count_q;

endmodule

`default_nettype wire

/* verif/rmsh_checker.sv */
`timescale 1ns / 1ps
// Checker that tracks the segment-length histogram and compares every bin read result.
module rmsh_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [rmsh_pkg::RATIO_W-1:0]  cfg_data,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [rmsh_pkg::KIND_W-1:0]   kind,
	input  wire logic [rmsh_pkg::SAMPLE_BITS_DEF-1:0] sample,
	input  wire logic                          end_of_line,
	input  wire logic [rmsh_pkg::BIN_W-1:0]    bin_index,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [rmsh_pkg::COUNT_BITS_DEF-1:0] bin_count,
	input  wire logic [rmsh_pkg::BIN_W-1:0]    bin_echo,
	output int                                 errors,
	output int                                 pending
);
	import rmsh_pkg::*;

	localparam int LINE_DEPTH = LINE_MAX_DEF;

	typedef struct {
		logic [COUNT_BITS_DEF-1:0] count;
		logic [BIN_W-1:0]          echo;
	} bin_read_t;

	bin_read_t                          read_backlog [$];
	bin_read_t                          oldest_read;
	bin_read_t                          fresh_read;
	logic [COUNT_BITS_DEF-1:0]          hist_model [LINE_DEPTH];
	logic signed [SAMPLE_BITS_DEF-1:0]  line_buf [LINE_DEPTH];
	int                                 line_len;
	logic [RATIO_W-1:0]                 ratio_q;

	function automatic bit departs(longint seg_sum, int seg_len, longint x);
		longint dev;
		longint mag_sum;
		dev = seg_sum - x * seg_len;
		if (dev < 0)
			dev = -dev;
		mag_sum = (seg_sum < 0) ? -seg_sum : seg_sum;
		return (dev << 16) > longint'(ratio_q) * mag_sum;
	endfunction

	task automatic segment_line();
		int     start;
		int     idx;
		bit     found;
		longint seg_sum;
		int     seg_len;
		longint x;
		start = 0;
		found = 0;
		seg_sum = 0;
		seg_len = 0;
		for (int j = 0; j < line_len; j++) begin
			x = line_buf[j];
			if (!found) begin
				if (seg_len != 0 && departs(seg_sum, seg_len, x)) begin
					start = j;
					found = 1;
				end else begin
					seg_sum += x;
					seg_len++;
				end
			end
		end
		seg_sum = 0;
		seg_len = 0;
		for (int j = 0; j < line_len; j++) begin
			idx = (start + j) % line_len;
			x = line_buf[idx];
			if (seg_len == 0) begin
				seg_sum = x;
				seg_len = 1;
			end else if (departs(seg_sum, seg_len, x)) begin
				if (hist_model[seg_len] != '1)
					hist_model[seg_len]++;
				seg_sum = 0;
				seg_len = 0;
			end else begin
				seg_sum += x;
				seg_len++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_backlog.delete();
			foreach (hist_model[b])
				hist_model[b] = '0;
			line_len = 0;
			ratio_q = RATIO_RESET;
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (read_backlog.size() == 0) begin
					$error("unexpected transaction: bin_count %0d, bin_echo %0d",
						bin_count, bin_echo);
					errors++;
				end else begin
					oldest_read = read_backlog.pop_front();
					if (bin_count !== oldest_read.count) begin
						$error("bin_count: expected %0d, actual %0d",
							oldest_read.count, bin_count);
						errors++;
					end
					if (bin_echo !== oldest_read.echo) begin
						$error("bin_echo: expected %0d, actual %0d",
							oldest_read.echo, bin_echo);
						errors++;
					end
				end
			end
			if (cfg_write)
				ratio_q = cfg_data;
			if (in_valid && !in_stall) begin
				case (kind)
					KIND_SAMPLE: begin
						if (line_len < LINE_DEPTH) begin
							line_buf[line_len] = sample;
							line_len++;
						end
						if (end_of_line) begin
							segment_line();
							line_len = 0;
						end
					end
					KIND_READ: begin
						fresh_read.count = hist_model[bin_index];
						fresh_read.echo = bin_index;
						read_backlog.insert(read_backlog.size(), fresh_read);
					end
					KIND_CLEAR: hist_model[bin_index] = '0;
					default: ;
				endcase
			end
		end
		pending = read_backlog.size();
	end

endmodule

/* verif/tb_running_mean_segment_histogram_unit.sv */
`timescale 1ns / 1ps
// Testbench top that drives lines, bin reads, clears, unused kinds and ratio writes into the segment histogram unit.
module tb_running_mean_segment_histogram_unit;
	import rmsh_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 4 * LINE_MAX_DEF + 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 175;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	logic [RATIO_W-1:0]          cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [KIND_W-1:0]           kind = '0;
	logic [SAMPLE_BITS_DEF-1:0]  sample = '0;
	logic                        end_of_line = 1'b0;
	logic [BIN_W-1:0]            bin_index = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [COUNT_BITS_DEF-1:0]   bin_count;
	logic [BIN_W-1:0]            bin_echo;
	int                          errors;
	int                          pending;

	int send_pct = 0;
	int stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sent = 0;

	running_mean_segment_histogram_unit DUT (.*);

	rmsh_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else
			out_stall = ($urandom_range(99) < stall_pct);
	end

	task automatic put_item(input logic [KIND_W-1:0] k, input logic [SAMPLE_BITS_DEF-1:0] s,
		input logic eol, input logic [BIN_W-1:0] b);
		while ($urandom_range(99) < send_pct)
			@(negedge clk);
		kind = k;
		sample = s;
		end_of_line = eol;
		bin_index = b;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
		if (k != KIND_UNUSED)
			sent++;
	endtask

	function automatic logic [BIN_W-1:0] pick_bin();
		logic [BIN_W-1:0] b;
		if ($urandom_range(1))
			b = BIN_W'($urandom_range(63));
		else
			b = BIN_W'($urandom_range(16, 1));
		return b;
	endfunction

	task automatic put_other(input logic [KIND_W-1:0] k);
		logic [SAMPLE_BITS_DEF-1:0] noise;
		noise = SAMPLE_BITS_DEF'($urandom);
		put_item(k, noise, 1'($urandom_range(1)), pick_bin());
	endtask

	function automatic int pick_base();
		int r;
		r = $urandom_range(3);
		if (r == 0)
			return $signed($urandom) >>> 8;
		if (r == 1)
			return int'($urandom_range(2000)) - 1000;
		if (r == 2)
			return 0;
		return $urandom_range(1) ? 8388607 - int'($urandom_range(100)) :
			-8388608 + int'($urandom_range(100));
	endfunction

	function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample(int base);
		int r;
		int v;
		int spread;
		r = $urandom_range(11);
		spread = ((base < 0) ? -base : base) / 4 + 1;
		if (r <= 6)
			v = base + int'($urandom_range(2 * spread)) - spread;
		else if (r == 7)
			v = -base;
		else if (r == 8)
			v = base * 3;
		else if (r == 9)
			v = 0;
		else if (r == 10)
			v = $signed($urandom) >>> 8;
		else
			v = $urandom_range(1) ? 8388607 : -8388608;
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[SAMPLE_BITS_DEF-1:0];
	endfunction

	task automatic put_line(input int n);
		int base;
		int r;
		base = pick_base();
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 8)
				put_other(KIND_READ);
			else if (r < 10)
				put_other(KIND_CLEAR);
			else if (r < 12)
				put_other(KIND_UNUSED);
			else if (r < 22)
				base = pick_base();
			put_item(KIND_SAMPLE, pick_sample(base), i == n - 1, pick_bin());
		end
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return int'($urandom_range(12, 1));
		if (r < 95)
			return int'($urandom_range(63, 13));
		return int'($urandom_range(72, 64));
	endfunction

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_ratio(input logic [RATIO_W-1:0] v);
		drain();
		cfg_write = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	initial begin
		logic [RATIO_W-1:0] ratio_plan [8];
		int phase_goal;
		int line_no;
		ratio_plan = '{RATIO_RESET, 16'd0, 16'hFFFF, 16'd0, 16'd16384, 16'd0, 16'hFFFF, 16'd0};
		ratio_plan[3] = RATIO_W'($urandom_range(65535));
		ratio_plan[5] = RATIO_W'($urandom_range(65535));
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);

		put_item(KIND_READ, 24'h000000, 1'b0, 6'd0);
		put_item(KIND_READ, 24'hFFFFFF, 1'b1, 6'd63);
		put_item(KIND_SAMPLE, 24'h7FFFFF, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h7FFFFF, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h800000, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h7FFFFF, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h7FFFFF, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h800000, 1'b1, 6'd0);
		put_item(KIND_SAMPLE, 24'h012345, 1'b1, 6'd0);
		put_item(KIND_SAMPLE, 24'h000000, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h000000, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h000000, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h000005, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h000000, 1'b0, 6'd0);
		put_item(KIND_SAMPLE, 24'h000000, 1'b1, 6'd0);
		put_item(KIND_UNUSED, 24'hFFFFFF, 1'b1, 6'd63);
		put_item(KIND_READ, 24'h000000, 1'b0, 6'd1);
		put_item(KIND_READ, 24'h000000, 1'b0, 6'd2);
		put_item(KIND_READ, 24'h000000, 1'b0, 6'd3);
		put_item(KIND_CLEAR, 24'h000000, 1'b0, 6'd2);
		put_item(KIND_READ, 24'h000000, 1'b0, 6'd2);

		for (int p = 0; p < 8; p++) begin
			write_ratio(ratio_plan[p]);
			send_pct = (p % 4 == 1) ? 88 : (p % 4 == 3) ? 33 : 0;
			stall_pct = (p % 4 == 2) ? 88 : (p % 4 == 3) ? 33 : 0;
			phase_goal = sent + PHASE_ITEMS;
			line_no = 0;
			while (sent < phase_goal) begin
				if (p == 0 && line_no == 2) begin
					hold_seq++;
					repeat (30)
						put_other(KIND_READ);
				end
				if (p == 1 && line_no == 3) begin
					while (pending != 0)
						@(negedge clk);
				end
				put_line(pick_len());
				repeat ($urandom_range(3))
					put_other(KIND_READ);
				line_no++;
			end
		end

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
